@@ hw/rtl/string_to_unsigned_parser_unit_assert.svh @@
// Assertion macros for the checker file of the parser unit.
`ifndef STRING_TO_UNSIGNED_PARSER_UNIT_ASSERT_SVH
`define STRING_TO_UNSIGNED_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define S2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/s2u_pkg.sv @@
// ----------------------------------------------------------------------------
// s2u_pkg
// Types, character codes and the digit decoder shared by the parser modules.
// ----------------------------------------------------------------------------
package s2u_pkg;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_RESET = BASE_DEC;

    // Byte address of the number_base register.
    localparam logic [1:0] ADDR_NUMBER_BASE = 2'd0;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       start;
        logic       blank;
        logic       plus;
        logic       minus;
        logic       x_char;
        logic       digit_ok;
        logic [5:0] digit;
        logic [5:0] base;
    } t_item;

    typedef struct packed {
        logic [31:0] value;
        logic [15:0] end_offset;
        logic        found_digits;
    } t_result;

    // Returns {valid, value}; letters of either case count from ten.
    function automatic logic [6:0] char_digit(input logic [7:0] ch);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                diff = ch - CH_ZERO;
                char_digit = {1'b1, diff[5:0]};
            end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
                diff = ch - CH_LO_A + 8'd10;
                char_digit = {1'b1, diff[5:0]};
            end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
                diff = ch - CH_UP_A + 8'd10;
                char_digit = {1'b1, diff[5:0]};
            end else begin
                char_digit = {1'b0, diff[5:0]};
            end
        end
    endfunction

endpackage

@@ hw/rtl/s2u_fifo.sv @@
// ----------------------------------------------------------------------------
// s2u_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module s2u_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/s2u_front.sv @@
// ----------------------------------------------------------------------------
// s2u_front
// Input side: classifies each accepted character and tags it with the base.
// ----------------------------------------------------------------------------
module s2u_front
    import s2u_pkg::*;
(
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_start_req,
    input  logic [5:0] i_number_base,
    output logic       o_q_push,
    output t_item      o_q_item,
    input  logic       i_q_full
);
    logic [6:0] dec;

    assign dec      = char_digit(i_ch);
    assign o_full   = i_q_full;
    assign o_q_push = i_push;

    always_comb begin
        o_q_item.start    = i_start_req;
        o_q_item.blank    = (i_ch == CH_SPACE) || (i_ch >= CH_TAB && i_ch <= CH_CR);
        o_q_item.plus     = (i_ch == CH_PLUS);
        o_q_item.minus    = (i_ch == CH_MINUS);
        o_q_item.x_char   = (i_ch == CH_LO_X) || (i_ch == CH_UP_X);
        o_q_item.digit_ok = dec[6];
        o_q_item.digit    = dec[5:0];
        // The base only matters on a start beat, where the back latches it.
        o_q_item.base     = i_number_base;
    end

endmodule

@@ hw/rtl/s2u_back.sv @@
// ----------------------------------------------------------------------------
// s2u_back
// Parse engine: runs the prefix/sign/digit sequencer and the multiply-add.
// ----------------------------------------------------------------------------
module s2u_back
    import s2u_pkg::*;
#(
    parameter int OFFSET_MAX = 65535
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_item_valid,
    input  t_item   i_item,
    output logic    o_item_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);
    localparam int POS_W = $clog2(OFFSET_MAX + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(OFFSET_MAX);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_SPACE,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [5:0]       r_base, n_base;
    logic             r_minus, n_minus;
    logic [31:0]      r_acc, n_acc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_seen, n_seen;
    logic [POS_W-1:0] idx;
    logic             to_prefix, to_digit, emit;

    assign o_item_pop = i_item_valid && !i_res_full;
    assign o_res_push = o_item_pop && emit;

    always_comb begin
        n_phase   = r_phase;
        n_base    = r_base;
        n_minus   = r_minus;
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_seen    = r_seen;
        to_prefix = 1'b0;
        to_digit  = 1'b0;
        emit      = 1'b0;
        if (i_item.start) begin
            n_phase = PH_SPACE;
            n_base  = i_item.base;
            n_minus = 1'b0;
            n_acc   = '0;
            n_pos   = '0;
            n_seen  = 1'b0;
        end
        idx = n_pos;
        if (n_phase != PH_DONE) begin
            n_pos = (idx < POS_MAX) ? idx + 1'b1 : POS_MAX;
            unique case (n_phase)
                PH_SPACE: begin
                    if (i_item.blank) begin
                        n_phase = PH_SPACE;
                    end else if (i_item.plus || i_item.minus) begin
                        n_minus = i_item.minus;
                        n_phase = PH_PREFIX;
                    end else begin
                        to_prefix = 1'b1;
                    end
                end
                PH_PREFIX: begin
                    to_prefix = 1'b1;
                end
                PH_ZERO: begin
                    n_phase = PH_DIGITS;
                    if (i_item.x_char) begin
                        if (n_base == BASE_AUTO) begin
                            n_base = BASE_HEX;
                        end
                    end else begin
                        // In auto mode the zero was only an octal prefix.
                        if (n_base == BASE_AUTO) begin
                            n_base = BASE_OCT;
                        end else begin
                            n_acc  = '0;
                            n_seen = 1'b1;
                        end
                        to_digit = 1'b1;
                    end
                end
                PH_DIGITS: begin
                    to_digit = 1'b1;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            if (to_prefix) begin
                if (i_item.digit_ok && i_item.digit == 6'd0 &&
                    (n_base == BASE_AUTO || n_base == BASE_HEX)) begin
                    n_phase = PH_ZERO;
                end else begin
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_DEC;
                    end
                    n_phase  = PH_DIGITS;
                    to_digit = 1'b1;
                end
            end
            if (to_digit) begin
                if (i_item.digit_ok && i_item.digit < n_base) begin
                    n_acc  = 32'(n_acc * 32'(n_base)) + 32'(i_item.digit);
                    n_seen = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                    emit    = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (n_seen) begin
            o_res.value        = n_minus ? (32'd0 - n_acc) : n_acc;
            o_res.end_offset   = 16'(idx);
            o_res.found_digits = 1'b1;
        end else begin
            o_res.value        = '0;
            o_res.end_offset   = '0;
            o_res.found_digits = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DONE;
            r_base  <= '0;
            r_minus <= 1'b0;
            r_acc   <= '0;
            r_pos   <= '0;
            r_seen  <= 1'b0;
        end else if (o_item_pop) begin
            r_phase <= n_phase;
            r_base  <= n_base;
            r_minus <= n_minus;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_seen  <= n_seen;
        end
    end

endmodule

@@ hw/rtl/string_to_unsigned_parser_unit.sv @@
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_unit
// Streaming strtoul-style parser: one character per beat, at most one result per string.
// ----------------------------------------------------------------------------
// Push one character per cycle, with i_start_req high on the first character
// of each string; the unit keeps taking a character every cycle as long as
// results are popped, since each character costs one pass through the parse
// engine's 32x6 multiply-add. A result enters the result queue on the edge at
// which the engine takes the character that ends the number (a NUL or any
// non-digit). An input queue of ITEM_DEPTH entries sits ahead of the engine
// and a result queue of RESULT_DEPTH entries behind it, so full rises only
// once both have filled while results are not popped. Characters after the
// end of a number, or before any start, make no result. The number_base
// register at byte address 0 is sampled on each start beat; 0 selects
// automatic base detection from the prefix.
module string_to_unsigned_parser_unit
    import s2u_pkg::*;
#(
    parameter int OFFSET_MAX   = 65535,
    parameter int ITEM_DEPTH   = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_ch,
    input  logic        i_start_req,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_value,
    output logic [15:0] o_end_offset,
    output logic        o_found_digits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [5:0] r_number_base;
    logic       q_push, q_full, q_empty, q_pop;
    t_item      q_in, q_out;
    logic       res_push, res_full;
    t_result    res_in, res_out;

    assign pready = 1'b1;
    assign prdata = {26'd0, r_number_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= BASE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_NUMBER_BASE) begin
            r_number_base <= pwdata[5:0];
        end
    end

    s2u_front u_front (
        .i_push        (push),
        .o_full        (full),
        .i_ch          (i_ch),
        .i_start_req   (i_start_req),
        .i_number_base (r_number_base),
        .o_q_push      (q_push),
        .o_q_item      (q_in),
        .i_q_full      (q_full)
    );

    s2u_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (ITEM_DEPTH)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    s2u_back #(
        .OFFSET_MAX (OFFSET_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (!q_empty),
        .i_item       (q_out),
        .o_item_pop   (q_pop),
        .i_res_full   (res_full),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    s2u_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_value        = res_out.value;
    assign o_end_offset   = res_out.end_offset;
    assign o_found_digits = res_out.found_digits;

endmodule

@@ hw/rtl/s2u_checker.sv @@
// ----------------------------------------------------------------------------
// s2u_checker
// Port-level checks for the parser unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "string_to_unsigned_parser_unit_assert.svh"

module s2u_checker
    import s2u_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] o_value,
    input logic [15:0] o_end_offset,
    input logic        o_found_digits,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [1:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A result that is not popped stays put.
    `S2U_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_value) && $stable(o_end_offset) && $stable(o_found_digits),
        "result changed while stalled")

    // A parse without digits reports zero value and zero offset.
    `S2U_ASSERT_NOW(a_no_digit_zero, i_clk, i_rst_n, !empty && !o_found_digits,
        o_value == 32'd0 && o_end_offset == 16'd0, "empty parse with nonzero fields")

    // Digits come before the ending character, so its offset is never zero.
    `S2U_ASSERT_NOW(a_found_offset, i_clk, i_rst_n, !empty && o_found_digits,
        o_end_offset != 16'd0, "digits found at offset zero")

    // The base register reads back the low six bits of what was written.
    `S2U_ASSERT_NEXT(a_base_readback, i_clk, i_rst_n,
        psel && penable && pwrite && pready && paddr == ADDR_NUMBER_BASE,
        prdata == {26'd0, $past(pwdata[5:0])}, "base register readback mismatch")

endmodule

bind string_to_unsigned_parser_unit s2u_checker u_s2u_checker (.*);
